>>> hw/rtl/wpfs_pkg.sv
// wpfs_pkg: shared widths, register map and codes of the window pair fitness scorer
// no dependencies; used by the channel interfaces, the top level and the checker
`default_nettype none

package wpfs_pkg;

  // sample field width of both logs
  localparam int unsigned SAMPLE_BITS = 16;

  // result field widths
  localparam int unsigned RATIO_W = 16;
  localparam int unsigned LEN_W   = 9;
  localparam int unsigned VDIFF_W = 17;
  localparam int unsigned TDIFF_W = 16;
  localparam int unsigned MEAN_W  = 16;

  // configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned VLIMIT_W   = 17;
  localparam int unsigned TLIMIT_W   = 16;
  localparam logic [VLIMIT_W-1:0] VLIMIT_RST = '1;
  localparam logic [TLIMIT_W-1:0] TLIMIT_RST = '1;

  // register index, taken from address bit 2
  typedef enum logic {
    REG_VOLTAGE_LIMIT = 1'b0,
    REG_TEMP_LIMIT    = 1'b1
  } reg_idx_e;

endpackage

`default_nettype wire

>>> hw/rtl/wpfs_if.sv
// wpfs_sample_if and wpfs_result_if: valid/ready channels of the scorer
// depends on wpfs_pkg for the field widths
`default_nettype none

interface wpfs_sample_if import wpfs_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] current_a;
  logic signed [SAMPLE_BITS-1:0] current_b;
  logic        [SAMPLE_BITS-1:0] voltage_a;
  logic        [SAMPLE_BITS-1:0] voltage_b;
  logic signed [SAMPLE_BITS-1:0] temp_a;
  logic signed [SAMPLE_BITS-1:0] temp_b;
  logic                          last_sample;

  modport source (
    output valid, current_a, current_b, voltage_a, voltage_b, temp_a, temp_b, last_sample,
    input  ready
  );
  modport sink (
    input  valid, current_a, current_b, voltage_a, voltage_b, temp_a, temp_b, last_sample,
    output ready
  );
endinterface

interface wpfs_result_if import wpfs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               gates_passed;
  logic [RATIO_W-1:0] max_rel_current_diff;
  logic [LEN_W-1:0]   window_length;
  logic [VDIFF_W-1:0] voltage_diff;
  logic [TDIFF_W-1:0] temp_diff;
  logic [MEAN_W-1:0]  mean_abs_current;

  modport source (
    output valid, gates_passed, max_rel_current_diff, window_length, voltage_diff,
           temp_diff, mean_abs_current,
    input  ready
  );
  modport sink (
    input  valid, gates_passed, max_rel_current_diff, window_length, voltage_diff,
           temp_diff, mean_abs_current,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/wpfs_div.sv
// wpfs_div: restoring divider, one quotient bit per cycle
// standalone; shared by the ratio and the mean computations of the scorer
`default_nettype none

module wpfs_div #(
  parameter int unsigned NUM_W = 25,
  parameter int unsigned DEN_W = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quot_o
);

  localparam int unsigned STEP_W = $clog2(NUM_W);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem_q;

  logic [DEN_W:0]    rem_shift;
  logic [DEN_W:0]    rem_sub;
  logic              q_bit;

  // shift in the next dividend bit and try the subtraction
  assign rem_shift = {rem_q, num_q[NUM_W-1]};
  assign rem_sub   = rem_shift - {1'b0, den_q};
  assign q_bit     = (rem_shift >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], q_bit};
      rem_q <= q_bit ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

`default_nettype wire

>>> hw/rtl/window_pair_fitness_scorer.sv
// window_pair_fitness_scorer: compares two aligned battery log windows sample by sample
// depends on wpfs_pkg, wpfs_sample_if, wpfs_result_if and wpfs_div
// a sample with no division leaves ready high; a sample that divides runs the divider in ST_RATIO;
//   a closing item runs it in ST_MEAN and then loads its result in ST_FIN; an empty window skips ST_MEAN
// one item at a time: ready is low while the divider runs and while a result waits to load
// reset: asynchronous active low; limits go to all ones, the next item starts a new window
`default_nettype none

module window_pair_fitness_scorer import wpfs_pkg::*; #(
  parameter int unsigned MAX_WINDOW = 256
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  wpfs_sample_if.sink                sample_i,
  wpfs_result_if.source              result_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  // count must hold MAX_WINDOW itself; sum of |a| up to 2^15 per sample
  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W = SAMPLE_BITS + CNT_W;
  // ratio dividend is |a-b| scaled by 256
  localparam int unsigned RNUM_W = SAMPLE_BITS + 8;
  localparam int unsigned NUM_W  = (SUM_W > RNUM_W) ? SUM_W : RNUM_W;
  localparam int unsigned DEN_W  = (CNT_W > SAMPLE_BITS) ? CNT_W : SAMPLE_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RATIO,
    ST_MEAN,
    ST_FIN
  } state_e;

  // control registers
  state_e              state_q, state_d;
  logic                inside_q, inside_d;
  logic                out_valid_q, out_valid_d;
  logic [VLIMIT_W-1:0] vlimit_q;
  logic [TLIMIT_W-1:0] tlimit_q;

  // window state, masked by inside_q so it needs no reset
  logic [SAMPLE_BITS-1:0] start_va_q, start_va_d;
  logic [SAMPLE_BITS-1:0] start_vb_q, start_vb_d;
  logic [TDIFF_W-1:0]     tgap_q, tgap_d;
  logic [RATIO_W-1:0]     max_q, max_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [VDIFF_W-1:0]     vdiff_q, vdiff_d;
  logic [MEAN_W-1:0]      mean_q, mean_d;

  // output register
  logic               res_pass_q;
  logic [RATIO_W-1:0] res_ratio_q;
  logic [LEN_W-1:0]   res_len_q;
  logic [VDIFF_W-1:0] res_vdiff_q;
  logic [TDIFF_W-1:0] res_tdiff_q;
  logic [MEAN_W-1:0]  res_mean_q;
  logic               res_load;

  // divider hookup
  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [NUM_W-1:0] div_quot;

  // per-item arithmetic
  logic                 in_fire;
  logic                 out_free;
  logic signed [SAMPLE_BITS:0] ia_x, ib_x, ta_x, tb_x, i_diff, t_diff;
  logic [SAMPLE_BITS:0] va_diff, start_vdiff_x;
  logic [SAMPLE_BITS-1:0] cur_mag, cur_gap, tgap_new, end_vdiff, start_vdiff;
  logic [SAMPLE_BITS-1:0] sva_cur, svb_cur;
  logic [RATIO_W-1:0]   max_cur, ratio_div;
  logic [SUM_W-1:0]     sum_cur;
  logic [CNT_W-1:0]     cnt_cur;
  logic [CNT_W+LEN_W-1:0] cnt_ext;
  logic [LEN_W-1:0]     len_sat;

  assign in_fire  = sample_i.valid && sample_i.ready;
  assign out_free = !out_valid_q || result_o.ready;

  // magnitudes, all in one extra bit
  assign ia_x    = {sample_i.current_a[SAMPLE_BITS-1], sample_i.current_a};
  assign ib_x    = {sample_i.current_b[SAMPLE_BITS-1], sample_i.current_b};
  assign ta_x    = {sample_i.temp_a[SAMPLE_BITS-1], sample_i.temp_a};
  assign tb_x    = {sample_i.temp_b[SAMPLE_BITS-1], sample_i.temp_b};
  assign i_diff  = ia_x - ib_x;
  assign t_diff  = ta_x - tb_x;
  assign cur_mag  = ia_x[SAMPLE_BITS] ? SAMPLE_BITS'(-ia_x) : ia_x[SAMPLE_BITS-1:0];
  assign cur_gap  = i_diff[SAMPLE_BITS] ? SAMPLE_BITS'(-i_diff) : i_diff[SAMPLE_BITS-1:0];
  assign tgap_new = t_diff[SAMPLE_BITS] ? SAMPLE_BITS'(-t_diff) : t_diff[SAMPLE_BITS-1:0];

  assign va_diff   = {1'b0, sample_i.voltage_a} - {1'b0, sample_i.voltage_b};
  assign end_vdiff = va_diff[SAMPLE_BITS] ? SAMPLE_BITS'(-va_diff) : va_diff[SAMPLE_BITS-1:0];

  // first item of a window sees an empty window
  assign sva_cur = inside_q ? start_va_q : sample_i.voltage_a;
  assign svb_cur = inside_q ? start_vb_q : sample_i.voltage_b;
  assign max_cur = inside_q ? max_q : '0;
  assign sum_cur = inside_q ? sum_q : '0;
  assign cnt_cur = inside_q ? cnt_q : '0;

  assign start_vdiff_x = {1'b0, sva_cur} - {1'b0, svb_cur};
  assign start_vdiff   = start_vdiff_x[SAMPLE_BITS] ? SAMPLE_BITS'(-start_vdiff_x)
                                                    : start_vdiff_x[SAMPLE_BITS-1:0];

  // ratio quotient saturates at all ones
  assign ratio_div = (div_quot[NUM_W-1:RATIO_W] != '0) ? '1 : div_quot[RATIO_W-1:0];

  // reported length saturates at 511
  assign cnt_ext = (CNT_W + LEN_W)'(cnt_q);
  assign len_sat = (cnt_ext > (CNT_W + LEN_W)'({LEN_W{1'b1}})) ? '1 : cnt_ext[LEN_W-1:0];

  // sequencer
  always_comb begin
    state_d     = state_q;
    inside_d    = inside_q;
    out_valid_d = out_valid_q;
    start_va_d  = start_va_q;
    start_vb_d  = start_vb_q;
    tgap_d      = tgap_q;
    max_d       = max_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    vdiff_d     = vdiff_q;
    mean_d      = mean_q;
    div_start   = 1'b0;
    div_num     = NUM_W'({cur_gap, 8'h00});
    div_den     = DEN_W'(cur_mag);
    res_load    = 1'b0;

    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          inside_d = 1'b1;
          max_d    = max_cur;
          sum_d    = sum_cur;
          cnt_d    = cnt_cur;
          if (!inside_q) begin
            start_va_d = sample_i.voltage_a;
            start_vb_d = sample_i.voltage_b;
            tgap_d     = tgap_new;
          end
          if (!sample_i.last_sample) begin
            if (cnt_cur < CNT_W'(MAX_WINDOW)) begin
              sum_d = sum_cur + SUM_W'(cur_mag);
              cnt_d = cnt_cur + 1'b1;
              if (cur_mag == '0) begin
                // zero current in log A: ratio is 0 or full scale
                if (cur_gap != '0) begin
                  max_d = '1;
                end
              end else begin
                div_start = 1'b1;
                state_d   = ST_RATIO;
              end
            end
          end else begin
            inside_d = 1'b0;
            vdiff_d  = VDIFF_W'(start_vdiff) + VDIFF_W'(end_vdiff);
            if (cnt_cur == '0) begin
              mean_d  = '0;
              state_d = ST_FIN;
            end else begin
              div_num   = NUM_W'(sum_cur);
              div_den   = DEN_W'(cnt_cur);
              div_start = 1'b1;
              state_d   = ST_MEAN;
            end
          end
        end
      end
      ST_RATIO: begin
        if (div_done) begin
          if (ratio_div > max_q) begin
            max_d = ratio_div;
          end
          state_d = ST_IDLE;
        end
      end
      ST_MEAN: begin
        if (div_done) begin
          // mean of 16-bit magnitudes never exceeds 2^15
          mean_d  = div_quot[MEAN_W-1:0];
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          res_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      inside_q    <= 1'b0;
      out_valid_q <= 1'b0;
      vlimit_q    <= VLIMIT_RST;
      tlimit_q    <= TLIMIT_RST;
    end else begin
      state_q     <= state_d;
      inside_q    <= inside_d;
      out_valid_q <= out_valid_d;
      // register write on the access cycle
      if (psel && penable && pwrite) begin
        case (reg_idx_e'(paddr[2]))
          REG_VOLTAGE_LIMIT: vlimit_q <= pwdata[VLIMIT_W-1:0];
          REG_TEMP_LIMIT:    tlimit_q <= pwdata[TLIMIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    start_va_q <= start_va_d;
    start_vb_q <= start_vb_d;
    tgap_q     <= tgap_d;
    max_q      <= max_d;
    sum_q      <= sum_d;
    cnt_q      <= cnt_d;
    vdiff_q    <= vdiff_d;
    mean_q     <= mean_d;
    if (res_load) begin
      // gates use limits as they stand; user must change config only while idle; unenforced
      res_pass_q  <= (vdiff_q < vlimit_q) && (tgap_q < tlimit_q);
      res_ratio_q <= max_q;
      res_len_q   <= len_sat;
      res_vdiff_q <= vdiff_q;
      res_tdiff_q <= tgap_q;
      res_mean_q  <= mean_q;
    end
  end

  // shared divider: ratio for each counted sample with nonzero log A current, the mean at close of a nonempty window
  wpfs_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // register readback
  always_comb begin
    case (reg_idx_e'(paddr[2]))
      REG_VOLTAGE_LIMIT: prdata = APB_DATA_W'(vlimit_q);
      REG_TEMP_LIMIT:    prdata = APB_DATA_W'(tlimit_q);
      default:           prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  assign sample_i.ready = (state_q == ST_IDLE);

  assign result_o.valid                = out_valid_q;
  assign result_o.gates_passed         = res_pass_q;
  assign result_o.max_rel_current_diff = res_ratio_q;
  assign result_o.window_length        = res_len_q;
  assign result_o.voltage_diff         = res_vdiff_q;
  assign result_o.temp_diff            = res_tdiff_q;
  assign result_o.mean_abs_current     = res_mean_q;

endmodule

`default_nettype wire

>>> hw/rtl/wpfs_checker.sv
// wpfs_checker: port-level assertions for window_pair_fitness_scorer
// depends on wpfs_pkg; attached to the top level by the bind at the end of this file
`default_nettype none

module wpfs_checker import wpfs_pkg::*; #(
  parameter int unsigned MAX_WINDOW = 256
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_i,
  input wire logic               in_last_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic               out_pass_i,
  input wire logic [RATIO_W-1:0] out_ratio_i,
  input wire logic [LEN_W-1:0]   out_len_i,
  input wire logic [VDIFF_W-1:0] out_vdiff_i,
  input wire logic [TDIFF_W-1:0] out_tdiff_i,
  input wire logic [MEAN_W-1:0]  out_mean_i
);

  // a stalled result holds
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pass_i)
      && $stable(out_ratio_i) && $stable(out_len_i) && $stable(out_vdiff_i)
      && $stable(out_tdiff_i) && $stable(out_mean_i))
    else $error("result changed while stalled");

  // closing a window leaves the block busy, with ready low, right after the last item
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("ready right after last item");

  // a sample that does not close a window makes no result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_last_i |=> !$rose(out_valid_i))
    else $error("result after non-last item");

  // the window length never exceeds the window capacity
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (32'(out_len_i) <= MAX_WINDOW))
    else $error("window length above capacity");

  // an empty window reports zero ratio and zero mean
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_len_i == '0) |-> (out_ratio_i == '0) && (out_mean_i == '0))
    else $error("empty window with nonzero measures");

endmodule

bind window_pair_fitness_scorer wpfs_checker #(
  .MAX_WINDOW(MAX_WINDOW)
) u_wpfs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (sample_i.valid),
  .in_ready_i (sample_i.ready),
  .in_last_i  (sample_i.last_sample),
  .out_valid_i(result_o.valid),
  .out_ready_i(result_o.ready),
  .out_pass_i (result_o.gates_passed),
  .out_ratio_i(result_o.max_rel_current_diff),
  .out_len_i  (result_o.window_length),
  .out_vdiff_i(result_o.voltage_diff),
  .out_tdiff_i(result_o.temp_diff),
  .out_mean_i (result_o.mean_abs_current)
);

`default_nettype wire
